>>> rtl/kci_pkg.sv
`default_nettype none

package kci_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KEY_AW   = $clog2(MAX_KEYS);
    localparam int CNT_W    = KEY_AW + 1;
    localparam int ENTRY_W  = 64;
    localparam int FETCH_N  = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_EVAL   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_SPLINE = 2'd2;

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_TENSION = 2'd1;
    localparam logic [1:0] REG_INTEGER = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_INS_CHK,
        S_SHIFT,
        S_PUT,
        S_FETCH,
        S_EVAL_DEC,
        S_DIV,
        S_MUL1,
        S_MUL2,
        S_BASIS,
        S_ACC,
        S_SUM,
        S_FIN
    } state_t;

endpackage

`default_nettype wire

>>> rtl/kci_ram.sv
`default_nettype none

module kci_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/keyframe_curve_interpolator.sv
`default_nettype none

// Sorted keyframe table (up to 64 keys of Q16.16 time and value) in one
// synchronous RAM, with insert, evaluate and clear items; one result per
// item, one item at a time. An insert scans the table at one key per cycle
// up to its position and then moves every later key up one place at one key
// per cycle. An evaluate scans to the segment at one key per cycle, reads
// eight neighbor entries and, unless in step mode or past the last key, runs
// a restoring divider for the 16-bit segment fraction and then a short
// multiply chain for the linear or Hermite sum. No clearing pass is needed
// after reset.

module keyframe_curve_interpolator (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 item_valid,
    output logic                      item_stall,
    input  wire logic [1:0]           operation,
    input  wire logic signed [31:0]   key_time,
    input  wire logic signed [31:0]   key_value,

    output logic                      result_valid,
    input  wire logic                 result_stall,
    output logic signed [31:0]        value_out,
    output logic [1:0]                status,
    output logic [kci_pkg::CNT_W-1:0] key_count,
    output logic signed [31:0]        begin_time,
    output logic signed [31:0]        end_time,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    import kci_pkg::*;

    // configuration
    logic [1:0]  mode_reg;
    logic [15:0] ten_reg;
    logic        int_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_LINEAR;
            ten_reg  <= 16'd2048;
            int_reg  <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_MODE:    mode_reg <= pwdata[1:0];
                REG_TENSION: ten_reg  <= pwdata[15:0];
                REG_INTEGER: int_reg  <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:    prdata = {30'd0, mode_reg};
            REG_TENSION: prdata = {16'd0, ten_reg};
            REG_INTEGER: prdata = {31'd0, int_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // key table
    logic                ram_we;
    logic [KEY_AW-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [KEY_AW-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    kci_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEYS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ovld_reg, ovld_next;

    // payload registers
    op_t                op_reg, op_next;
    logic [31:0]        q_reg, q_next;
    logic [31:0]        kv_reg, kv_next;
    logic [31:0]        begin_reg, begin_next;
    logic [31:0]        end_reg, end_next;
    logic [CNT_W-1:0]   c_reg, c_next;
    logic [CNT_W-1:0]   f_reg, f_next;
    logic               dup_reg, dup_next;
    logic [CNT_W-1:0]   a_reg, a_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic               pend_reg, pend_next;
    logic [KEY_AW-1:0]  wa_reg, wa_next;
    logic [3:0]         k_reg, k_next;
    logic [ENTRY_W-1:0] fe_reg [0:FETCH_N-1];
    logic [ENTRY_W-1:0] fe_next [0:FETCH_N-1];
    logic [32:0]        r_reg, r_next;
    logic [32:0]        dt_reg, dt_next;
    logic [15:0]        tq_reg, tq_next;
    logic [4:0]         dc_reg, dc_next;
    logic [31:0]        t2_reg, t2_next;
    logic [47:0]        t3_reg, t3_next;
    logic signed [49:0] m0raw_reg, m0raw_next;
    logic signed [49:0] m1raw_reg, m1raw_next;
    logic signed [38:0] m0_reg, m0_next;
    logic signed [38:0] m1_reg, m1_next;
    logic signed [19:0] h2_reg, h2_next;
    logic signed [19:0] h3_reg, h3_next;
    logic signed [19:0] h4_reg, h4_next;
    logic signed [52:0] p1_reg, p1_next;
    logic signed [58:0] p2_reg, p2_next;
    logic signed [58:0] p3_reg, p3_next;
    logic signed [47:0] res_reg, res_next;
    status_t            st_reg, st_next;
    logic               use_res_reg, use_res_next;
    logic signed [31:0] vout_reg, vout_next;
    status_t            sout_reg, sout_next;
    logic [CNT_W-1:0]   cout_reg, cout_next;
    logic [31:0]        bout_reg, bout_next;
    logic [31:0]        eout_reg, eout_next;

    // datapath helpers
    logic               accept;
    logic [CNT_W-1:0]   start_idx;
    logic signed [31:0] rd_t;
    logic               is_ins;
    logic               stop;
    logic signed [31:0] t0, t1, v0, v1;
    logic signed [32:0] dv;
    logic signed [32:0] num;
    logic               closed;
    logic               spline;
    logic signed [32:0] d0, d1;
    logic [33:0]        r2;
    logic [CNT_W-1:0]   fa;
    logic signed [51:0] t3s, t2s, ts, e2, e3, e4;
    logic signed [60:0] acc;
    logic signed [31:0] sat;
    logic signed [32:0] mag;
    logic               out_free;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign out_free   = !ovld_reg || !result_stall;
    assign is_ins     = (op_reg == OP_INSERT);
    assign rd_t       = $signed(ram_rdata[63:32]);
    assign stop       = ($signed(q_reg) < rd_t) || (is_ins && ($signed(q_reg) == rd_t));
    assign start_idx  = (operation == OP_INSERT) ? CNT_W'(0) : CNT_W'(1);

    assign t0 = $signed(fe_reg[0][63:32]);
    assign v0 = $signed(fe_reg[0][31:0]);
    assign t1 = $signed(fe_reg[1][63:32]);
    assign v1 = $signed(fe_reg[1][31:0]);
    assign dv = 33'(v1) - 33'(v0);
    assign num = 33'(signed'(q_reg)) - 33'(t0);
    assign closed = (fe_reg[4][31:0] == fe_reg[7][31:0]);
    assign spline = (mode_reg == MODE_SPLINE) && !int_reg && (cnt_reg >= CNT_W'(3));

    // neighbor tangent differences
    always_comb
    begin
        if (f_reg >= CNT_W'(2))
        begin
            d0 = 33'($signed(fe_reg[1][31:0])) - 33'($signed(fe_reg[2][31:0]));
        end
        else if (closed)
        begin
            d0 = 33'($signed(fe_reg[5][31:0])) - 33'($signed(fe_reg[6][31:0]));
        end
        else
        begin
            d0 = 33'sd0;
        end
        if (f_reg + CNT_W'(1) < cnt_reg)
        begin
            d1 = 33'($signed(fe_reg[3][31:0])) - 33'($signed(fe_reg[0][31:0]));
        end
        else if (closed)
        begin
            d1 = 33'($signed(fe_reg[5][31:0])) - 33'($signed(fe_reg[6][31:0]));
        end
        else
        begin
            d1 = 33'sd0;
        end
    end

    // fetch address list
    always_comb
    begin
        unique case (k_reg[2:0])
            3'd0: fa = f_reg - CNT_W'(1);
            3'd1: fa = (f_reg >= cnt_reg) ? cnt_reg - CNT_W'(1) : f_reg;
            3'd2: fa = (f_reg >= CNT_W'(2)) ? f_reg - CNT_W'(2) : CNT_W'(0);
            3'd3: fa = (f_reg + CNT_W'(1) < cnt_reg) ? f_reg + CNT_W'(1) : CNT_W'(0);
            3'd4: fa = CNT_W'(0);
            3'd5: fa = CNT_W'(1);
            3'd6: fa = (cnt_reg >= CNT_W'(2)) ? cnt_reg - CNT_W'(2) : CNT_W'(0);
            3'd7: fa = cnt_reg - CNT_W'(1);
            default: fa = CNT_W'(0);
        endcase
    end

    assign r2  = {r_reg, 1'b0};
    assign t3s = $signed({4'd0, t3_reg});
    assign t2s = $signed({4'd0, t2_reg, 16'd0});
    assign ts  = $signed({4'd0, tq_reg, 32'd0});
    assign e2  = t2s + t2s + t2s - t3s - t3s;
    assign e3  = t3s - t2s - t2s + ts;
    assign e4  = t3s - t2s;
    assign acc = 61'(p1_reg) + 61'(p2_reg) + 61'(p3_reg);

    // saturate and optional truncation
    always_comb
    begin
        if (res_reg > 48'sd2147483647)
        begin
            sat = 32'sh7fffffff;
        end
        else if (res_reg < -48'sd2147483648)
        begin
            sat = 32'sh80000000;
        end
        else
        begin
            sat = 32'(res_reg);
        end
        mag = -33'(sat);
        mag = mag & ~33'h0ffff;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovld_next    = ovld_reg && result_stall;
        op_next      = op_reg;
        q_next       = q_reg;
        kv_next      = kv_reg;
        begin_next   = begin_reg;
        end_next     = end_reg;
        c_next       = c_reg;
        f_next       = f_reg;
        dup_next     = dup_reg;
        a_next       = a_reg;
        rem_next     = rem_reg;
        pend_next    = pend_reg;
        wa_next      = wa_reg;
        k_next       = k_reg;
        fe_next      = fe_reg;
        r_next       = r_reg;
        dt_next      = dt_reg;
        tq_next      = tq_reg;
        dc_next      = dc_reg;
        t2_next      = t2_reg;
        t3_next      = t3_reg;
        m0raw_next   = m0raw_reg;
        m1raw_next   = m1raw_reg;
        m0_next      = m0_reg;
        m1_next      = m1_reg;
        h2_next      = h2_reg;
        h3_next      = h3_reg;
        h4_next      = h4_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        p3_next      = p3_reg;
        res_next     = res_reg;
        st_next      = st_reg;
        use_res_next = use_res_reg;
        vout_next    = vout_reg;
        sout_next    = sout_reg;
        cout_next    = cout_reg;
        bout_next    = bout_reg;
        eout_next    = eout_reg;
        ram_we       = 1'b0;
        ram_waddr    = wa_reg;
        ram_wdata    = ram_rdata;
        ram_raddr    = c_reg[KEY_AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = start_idx[KEY_AW-1:0];
                if (accept)
                begin
                    op_next      = op_t'(operation);
                    q_next       = key_time;
                    kv_next      = key_value;
                    st_next      = ST_OK;
                    use_res_next = 1'b0;
                    dup_next     = 1'b0;
                    c_next       = start_idx;
                    unique case (op_t'(operation))
                        OP_INSERT, OP_EVAL:
                        begin
                            if (operation == OP_EVAL && cnt_reg == CNT_W'(0))
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_FIN;
                            end
                            else if (start_idx >= cnt_reg)
                            begin
                                f_next     = start_idx;
                                state_next = (operation == OP_INSERT) ? S_INS_CHK : S_FETCH;
                                k_next     = 4'd0;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = CNT_W'(0);
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                ram_raddr = KEY_AW'(c_reg + CNT_W'(1));
                k_next    = 4'd0;
                if (stop)
                begin
                    f_next     = c_reg;
                    dup_next   = is_ins && ($signed(q_reg) == rd_t);
                    state_next = is_ins ? S_INS_CHK : S_FETCH;
                end
                else if (c_reg + CNT_W'(1) >= cnt_reg)
                begin
                    f_next     = c_reg + CNT_W'(1);
                    state_next = is_ins ? S_INS_CHK : S_FETCH;
                end
                else
                begin
                    c_next = c_reg + CNT_W'(1);
                end
            end

            S_INS_CHK:
            begin
                pend_next = 1'b0;
                a_next    = cnt_reg - CNT_W'(1);
                rem_next  = cnt_reg - f_reg;
                if (dup_reg)
                begin
                    st_next    = ST_DUP;
                    state_next = S_FIN;
                end
                else if (cnt_reg >= CNT_W'(MAX_KEYS))
                begin
                    st_next    = ST_FULL;
                    state_next = S_FIN;
                end
                else if (f_reg == cnt_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                ram_we    = pend_reg;
                ram_waddr = wa_reg;
                ram_wdata = ram_rdata;
                ram_raddr = a_reg[KEY_AW-1:0];
                if (rem_reg != CNT_W'(0))
                begin
                    pend_next = 1'b1;
                    wa_next   = KEY_AW'(a_reg + CNT_W'(1));
                    a_next    = a_reg - CNT_W'(1);
                    rem_next  = rem_reg - CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_PUT;
                    end
                end
            end

            S_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = f_reg[KEY_AW-1:0];
                ram_wdata = {q_reg, kv_reg};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (f_reg == CNT_W'(0))
                begin
                    begin_next = q_reg;
                end
                if (f_reg == cnt_reg)
                begin
                    end_next = q_reg;
                end
                state_next = S_FIN;
            end

            S_FETCH:
            begin
                ram_raddr = fa[KEY_AW-1:0];
                if (k_reg != 4'd0)
                begin
                    fe_next[k_reg[2:0] - 3'd1] = ram_rdata;
                end
                if (k_reg == 4'(FETCH_N))
                begin
                    state_next = S_EVAL_DEC;
                end
                else
                begin
                    k_next = k_reg + 4'd1;
                end
            end

            S_EVAL_DEC:
            begin
                use_res_next = 1'b1;
                r_next       = num[32] ? 33'd0 : 33'(num);
                dt_next      = 33'(33'(t1) - 33'(t0));
                dc_next      = 5'd0;
                tq_next      = 16'd0;
                if (f_reg >= cnt_reg || mode_reg == MODE_STEP)
                begin
                    res_next   = 48'(v0);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (r2 >= {1'b0, dt_reg})
                begin
                    r_next  = 33'(r2 - {1'b0, dt_reg});
                    tq_next = {tq_reg[14:0], 1'b1};
                end
                else
                begin
                    r_next  = r2[32:0];
                    tq_next = {tq_reg[14:0], 1'b0};
                end
                dc_next = dc_reg + 5'd1;
                if (dc_reg == 5'd15)
                begin
                    if (spline)
                    begin
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        h2_next    = $signed({4'd0, tq_next});
                        h3_next    = 20'sd0;
                        h4_next    = 20'sd0;
                        m0_next    = 39'sd0;
                        m1_next    = 39'sd0;
                        state_next = S_ACC;
                    end
                end
            end

            S_MUL1:
            begin
                t2_next    = 32'(tq_reg) * 32'(tq_reg);
                m0raw_next = 50'(d0) * 50'($signed({1'b0, ten_reg}));
                m1raw_next = 50'(d1) * 50'($signed({1'b0, ten_reg}));
                state_next = S_MUL2;
            end

            S_MUL2:
            begin
                t3_next    = 48'(t2_reg) * 48'(tq_reg);
                m0_next    = 39'((m0raw_reg + 50'sd2048) >>> 12);
                m1_next    = 39'((m1raw_reg + 50'sd2048) >>> 12);
                state_next = S_BASIS;
            end

            S_BASIS:
            begin
                h2_next    = 20'((e2 + 52'sd2147483648) >>> 32);
                h3_next    = 20'((e3 + 52'sd2147483648) >>> 32);
                h4_next    = 20'((e4 + 52'sd2147483648) >>> 32);
                state_next = S_ACC;
            end

            S_ACC:
            begin
                p1_next    = 53'(dv) * 53'(h2_reg);
                p2_next    = 59'(m0_reg) * 59'(h3_reg);
                p3_next    = 59'(m1_reg) * 59'(h4_reg);
                state_next = S_SUM;
            end

            S_SUM:
            begin
                res_next   = 48'(v0) + 48'((acc + 61'sd32768) >>> 16);
                state_next = S_FIN;
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    ovld_next = 1'b1;
                    sout_next = st_reg;
                    cout_next = cnt_reg;
                    bout_next = (cnt_reg == CNT_W'(0)) ? 32'd0 : begin_reg;
                    eout_next = (cnt_reg == CNT_W'(0)) ? 32'd0 : end_reg;
                    if (!use_res_reg)
                    begin
                        vout_next = 32'sd0;
                    end
                    else if (!int_reg)
                    begin
                        vout_next = sat;
                    end
                    else if (sat >= 32'sd0)
                    begin
                        vout_next = sat & ~32'sh0000ffff;
                    end
                    else
                    begin
                        vout_next = 32'(-mag);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        q_reg       <= q_next;
        kv_reg      <= kv_next;
        begin_reg   <= begin_next;
        end_reg     <= end_next;
        c_reg       <= c_next;
        f_reg       <= f_next;
        dup_reg     <= dup_next;
        a_reg       <= a_next;
        rem_reg     <= rem_next;
        pend_reg    <= pend_next;
        wa_reg      <= wa_next;
        k_reg       <= k_next;
        fe_reg      <= fe_next;
        r_reg       <= r_next;
        dt_reg      <= dt_next;
        tq_reg      <= tq_next;
        dc_reg      <= dc_next;
        t2_reg      <= t2_next;
        t3_reg      <= t3_next;
        m0raw_reg   <= m0raw_next;
        m1raw_reg   <= m1raw_next;
        m0_reg      <= m0_next;
        m1_reg      <= m1_next;
        h2_reg      <= h2_next;
        h3_reg      <= h3_next;
        h4_reg      <= h4_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        p3_reg      <= p3_next;
        res_reg     <= res_next;
        st_reg      <= st_next;
        use_res_reg <= use_res_next;
        vout_reg    <= vout_next;
        sout_reg    <= sout_next;
        cout_reg    <= cout_next;
        bout_reg    <= bout_next;
        eout_reg    <= eout_next;
    end

    assign result_valid = ovld_reg;
    assign value_out    = vout_reg;
    assign status       = sout_reg;
    assign key_count    = cout_reg;
    assign begin_time   = bout_reg;
    assign end_time     = eout_reg;

endmodule

`default_nettype wire
